FILE: hdl/salru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_pkg
// Shared types and constants of the LRU cache tag store.
// ----------------------------------------------------------------------------
package salru_pkg;

  // Result item fields
  localparam int unsigned HitW      = 1;
  localparam int unsigned OutWayW   = 2;
  localparam int unsigned ResTdataW = 8;

  // Result item, last field in the lowest bit
  typedef struct packed {
    logic [OutWayW-1:0] way;
    logic               hit;
  } res_t;

  localparam int unsigned ResW = $bits(res_t);

endpackage

FILE: hdl/set_assoc_cache_lru_tags_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_tags_top
// Tag store of a set-associative cache with true LRU replacement.
// ----------------------------------------------------------------------------
//  Channel   Dir   Signals                Item
//  s_axis    in    tvalid tready tdata    byte address
//  m_axis    out   tvalid tready tdata    hit flag and way used
//
//  One item per cycle while results are taken; from acceptance to result the
//  set row is read from the tag RAM, then compare, way choice and rank update
//  run and write back the row while the result is registered.
//  A set written back in the cycle the next item reads it is forwarded.
//  Reset clears all valid bits at once; tags and ranks need no clearing.
//  A stalled result holds both stages; the input stalls only when both are full.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_tags_top #(
  parameter int unsigned CACHE_BYTES = 4096,
  parameter int unsigned BLOCK_BYTES = 16,
  parameter int unsigned WAYS        = 4,
  parameter int unsigned ADDR_BITS   = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [((ADDR_BITS+7)/8)*8-1:0] s_axis_tdata,   // [ADDR_BITS-1:0] address
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [salru_pkg::ResTdataW-1:0] m_axis_tdata   // [0] hit, [2:1] way
);

  localparam int unsigned SetRaw   = CACHE_BYTES / BLOCK_BYTES / WAYS;
  localparam int unsigned SetAlloc = (SetRaw > 0) ? SetRaw : 1;
  localparam int unsigned OffBits  = $clog2(BLOCK_BYTES + 1) - 1;
  localparam int unsigned IdxBits  = $clog2(SetAlloc + 1) - 1;
  localparam int unsigned Sets     = 1 << IdxBits;
  localparam int unsigned SetW     = (IdxBits > 0) ? IdxBits : 1;
  localparam int unsigned TagRaw   = ADDR_BITS - OffBits - IdxBits;
  localparam int unsigned TagW     = (ADDR_BITS > OffBits + IdxBits) ? TagRaw : 1;
  localparam int unsigned WayW     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RankW    = WayW;
  localparam int unsigned RowW     = WAYS * (TagW + RankW);
  localparam logic [SetW-1:0] SetMask = SetW'(Sets - 1);

  logic [ADDR_BITS-1:0] addr_in;
  logic [SetW-1:0]      set_in;
  logic [TagW-1:0]      tag_in;
  logic                 accept;
  logic                 advance;
  logic                 wr_en;

  logic                 s1_valid_q, s1_valid_d;
  logic [SetW-1:0]      set_q;
  logic [TagW-1:0]      tag_q;
  logic                 fwd_q, fwd_d;
  logic [RowW-1:0]      fwd_row_q;

  logic                 out_valid_q, out_valid_d;
  salru_pkg::res_t      res_q;

  logic [Sets-1:0][WAYS-1:0] valid_q;

  logic [RowW-1:0]                 rd_row;
  logic [RowW-1:0]                 cur_row;
  logic [RowW-1:0]                 new_row;
  logic [WAYS-1:0][TagW-1:0]       cur_tags, new_tags;
  logic [WAYS-1:0][RankW-1:0]      cur_ranks, new_ranks;
  logic [WAYS-1:0]                 cur_valid;
  logic                            lk_hit;
  logic                            lk_all_valid;
  logic [WayW-1:0]                 lk_way;

  assign addr_in = s_axis_tdata[ADDR_BITS-1:0];
  assign set_in  = SetW'(addr_in >> OffBits) & SetMask;
  assign tag_in  = TagW'(addr_in >> (OffBits + IdxBits));

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign wr_en         = s1_valid_q && advance;

  salru_tag_ram #(
    .DEPTH  (Sets),
    .ADDR_W (SetW),
    .DATA_W (RowW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (set_q),
    .wdata_i (new_row),
    .re_i    (accept),
    .raddr_i (set_in),
    .rdata_o (rd_row)
  );

  // Take the row just written back when the RAM read missed it
  assign cur_row                = fwd_q ? fwd_row_q : rd_row;
  assign {cur_ranks, cur_tags}  = cur_row;
  assign cur_valid              = valid_q[set_q];
  assign new_row                = {new_ranks, new_tags};

  salru_lookup #(
    .WAYS   (WAYS),
    .WAY_W  (WayW),
    .TAG_W  (TagW),
    .RANK_W (RankW)
  ) u_lookup (
    .tag_i       (tag_q),
    .valid_i     (cur_valid),
    .tags_i      (cur_tags),
    .ranks_i     (cur_ranks),
    .hit_o       (lk_hit),
    .all_valid_o (lk_all_valid),
    .way_o       (lk_way),
    .tags_o      (new_tags),
    .ranks_o     (new_ranks)
  );

  assign s1_valid_d  = s_axis_tready ? s_axis_tvalid : s1_valid_q;
  assign fwd_d       = s_axis_tready ? (accept && wr_en && (set_q == set_in)) : fwd_q;
  assign out_valid_d = advance ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      fwd_q       <= fwd_d;
      out_valid_q <= out_valid_d;
      if (wr_en) begin
        valid_q[set_q][lk_way] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      set_q     <= set_in;
      tag_q     <= tag_in;
      fwd_row_q <= new_row;
    end
    if (wr_en) begin
      res_q.hit <= lk_hit;
      res_q.way <= salru_pkg::OutWayW'(lk_way);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = salru_pkg::ResTdataW'(res_q);

  // Input stalls only when both stages hold an item
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with a free stage");

  // Forwarded row only belongs to an item in the lookup stage
  a_fwd_owned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_valid_q)
    else $error("forward flag without an item in the lookup stage");

  // A hit only ever comes from a valid way
  a_hit_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && lk_hit) |-> cur_valid[lk_way])
    else $error("hit on an invalid way");

  // A miss in a set with free ways fills an empty way
  a_fill_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !lk_hit && !lk_all_valid) |-> !cur_valid[lk_way])
    else $error("miss evicted a valid way while a free way remained");

  // The way just filled is valid from the next cycle on
  a_fill_sets_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !lk_hit) |=> valid_q[$past(set_q)][$past(lk_way)])
    else $error("filled way not marked valid");

endmodule

FILE: hdl/salru_tag_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_tag_ram
// One row per set holding the tags and recency ranks of all ways.
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
module salru_tag_ram #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6,
  parameter int unsigned DATA_W = 96
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/salru_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_lookup
// Tag compare, way choice and LRU rank update for one set.
// ----------------------------------------------------------------------------
module salru_lookup #(
  parameter int unsigned WAYS   = 4,
  parameter int unsigned WAY_W  = 2,
  parameter int unsigned TAG_W  = 22,
  parameter int unsigned RANK_W = 2
) (
  input  logic [TAG_W-1:0]             tag_i,
  input  logic [WAYS-1:0]              valid_i,
  input  logic [WAYS-1:0][TAG_W-1:0]   tags_i,
  input  logic [WAYS-1:0][RANK_W-1:0]  ranks_i,
  output logic                         hit_o,
  output logic                         all_valid_o,
  output logic [WAY_W-1:0]             way_o,
  output logic [WAYS-1:0][TAG_W-1:0]   tags_o,
  output logic [WAYS-1:0][RANK_W-1:0]  ranks_o
);

  localparam logic [RANK_W-1:0] RankOldest = RANK_W'(WAYS - 1);
  localparam logic [RANK_W:0]   RankNone   = (RANK_W + 1)'(WAYS);

  logic [WAYS-1:0]  hit_vec;
  logic [WAYS-1:0]  oldest_vec;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] free_way;
  logic [WAY_W-1:0] old_way;
  logic [RANK_W:0]  rank_limit;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      hit_vec[i]    = valid_i[i] && (tags_i[i] == tag_i);
      oldest_vec[i] = (ranks_i[i] == RankOldest);
    end
  end

  // Lowest-numbered way wins in each search
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    old_way  = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_way = WAY_W'(i);
      end
      if (!valid_i[i]) begin
        free_way = WAY_W'(i);
      end
      if (oldest_vec[i]) begin
        old_way = WAY_W'(i);
      end
    end
  end

  assign hit_o       = |hit_vec;
  assign all_valid_o = &valid_i;

  always_comb begin
    if (hit_o) begin
      way_o = hit_way;
    end else if (!all_valid_o) begin
      way_o = free_way;
    end else begin
      way_o = old_way;
    end
  end

  // A fresh fill ages every valid way; otherwise only the younger ones age
  assign rank_limit = (hit_o || all_valid_o) ? {1'b0, ranks_i[way_o]} : RankNone;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      tags_o[i]  = tags_i[i];
      ranks_o[i] = ranks_i[i];
      if (WAY_W'(i) == way_o) begin
        ranks_o[i] = '0;
        if (!hit_o) begin
          tags_o[i] = tag_i;
        end
      end else if (valid_i[i] && ({1'b0, ranks_i[i]} < rank_limit) &&
                   (ranks_i[i] < RankOldest)) begin
        ranks_o[i] = ranks_i[i] + RANK_W'(1);
      end
    end
  end

endmodule

FILE: sim/salru_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_checker
// Watches both streams of the LRU tag store, keeps its own copy of tags,
// valid bits and recency ranks, and compares each hit/way result in order.
// ----------------------------------------------------------------------------
module salru_checker
  import salru_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  input  logic                 s_axis_tready_i,
  input  logic [31:0]          s_axis_tdata_i,   // [31:0] address
  input  logic                 m_axis_tvalid_i,
  input  logic                 m_axis_tready_i,
  input  logic [ResTdataW-1:0] m_axis_tdata_i,   // [0] hit, [2:1] way
  output int                   err_count_o,
  output int                   pending_o
);

  localparam int OffW  = 4;
  localparam int IdxW  = 6;
  localparam int TagW  = 22;
  localparam int Sets  = 1 << IdxW;
  localparam int Ways  = 4;
  localparam int RankW = 2;

  logic [TagW-1:0]  tag_mem   [Sets][Ways];
  logic             valid_mem [Sets][Ways];
  logic [RankW-1:0] rank_mem  [Sets][Ways];

  res_t lookup_q [$];
  res_t got_r;
  res_t want_r;
  int   errs     = 0;
  int   pend_cnt = 0;

  assign err_count_o = errs;
  assign pending_o   = pend_cnt;

  // Promote way w to most recent; valid ways younger than its old rank age by one
  task automatic make_recent(input int s, input int w, input bit was_valid);
    int old;
    old = was_valid ? int'(rank_mem[s][w]) : Ways;
    for (int i = 0; i < Ways; i++) begin
      if (i != w && valid_mem[s][i] && int'(rank_mem[s][i]) < old &&
          int'(rank_mem[s][i]) < Ways - 1)
        rank_mem[s][i] = rank_mem[s][i] + 1'b1;
    end
    rank_mem[s][w] = '0;
  endtask

  task automatic predict_lookup(input logic [31:0] addr);
    logic [TagW-1:0] tag;
    int              s;
    int              w;
    int              best;
    bit              hit;
    bit              found;
    res_t            r;
    tag   = addr[31 -: TagW];
    s     = int'(addr[OffW +: IdxW]);
    w     = 0;
    hit   = 1'b0;
    found = 1'b0;
    for (int i = 0; i < Ways; i++) begin
      if (!hit && valid_mem[s][i] && tag_mem[s][i] == tag) begin
        hit = 1'b1;
        w   = i;
      end
    end
    if (hit) begin
      make_recent(s, w, 1'b1);
    end else begin
      for (int i = 0; i < Ways; i++) begin
        if (!found && !valid_mem[s][i]) begin
          found = 1'b1;
          w     = i;
        end
      end
      if (found) begin
        make_recent(s, w, 1'b0);
      end else begin
        // victim: lowest-numbered way of highest rank
        best = 0;
        w    = 0;
        for (int i = 0; i < Ways; i++) begin
          if (int'(rank_mem[s][i]) > best) begin
            best = int'(rank_mem[s][i]);
            w    = i;
          end
        end
        make_recent(s, w, 1'b1);
      end
      tag_mem[s][w]   = tag;
      valid_mem[s][w] = 1'b1;
    end
    r.hit = hit;
    r.way = OutWayW'(w);
    lookup_q.insert(lookup_q.size(), r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Sets; s++) begin
        for (int w = 0; w < Ways; w++) begin
          valid_mem[s][w] = 1'b0;
          rank_mem[s][w]  = '0;
        end
      end
      lookup_q.delete();
      pend_cnt = 0;
    end else begin
      // results first: a result never belongs to the item accepted at the same edge
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got_r = res_t'(m_axis_tdata_i[ResW-1:0]);
        if (lookup_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected result: expected none, got hit=%0d way=%0d",
                   $time, got_r.hit, got_r.way);
        end else begin
          want_r = lookup_q.pop_front();
          if (got_r.hit !== want_r.hit || got_r.way !== want_r.way) begin
            errs++;
            $display("%0t: mismatch: expected hit=%0d way=%0d, got hit=%0d way=%0d",
                     $time, want_r.hit, want_r.way, got_r.hit, got_r.way);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        predict_lookup(s_axis_tdata_i);
      pend_cnt = lookup_q.size();
    end
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives address items into the LRU tag store under varying back-pressure;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import salru_pkg::*;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [ResTdataW-1:0] m_axis_tdata;

  int          err_count;
  int          pending_cnt;
  int          snd_idle = 0;
  int          rcv_idle = 0;
  logic [21:0] tag_pool [6];
  logic [5:0]  hot_sets [4];

  set_assoc_cache_lru_tags_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  salru_checker u_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .err_count_o     (err_count),
    .pending_o       (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // receiver back-pressure
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  function automatic logic [31:0] make_addr(logic [21:0] tag, logic [5:0] set_idx,
                                            logic [3:0] off);
    return {tag, set_idx, off};
  endfunction

  task automatic send_addr(input logic [31:0] addr);
    while ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // hold off the sender until every lookup has returned
  task automatic drain_lookups();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_cnt != 0);
  endtask

  // mostly a few tags over a few hot sets, so hits and evictions both happen
  task automatic send_random_phase(input int n);
    logic [5:0] set_idx;
    for (int i = 0; i < 6; i++) tag_pool[i] = 22'($urandom());
    for (int i = 0; i < 4; i++) hot_sets[i] = 6'($urandom());
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 75) begin
        set_idx = ($urandom_range(9) < 8) ? hot_sets[$urandom_range(3)]
                                           : 6'($urandom_range(63));
        send_addr(make_addr(tag_pool[$urandom_range(5)], set_idx, 4'($urandom())));
      end else begin
        send_addr($urandom());
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    snd_idle = 12;
    rcv_idle = 68;

    // fill one set, hit in it, then evict in LRU order
    send_addr(make_addr(22'd0, 6'd0, 4'h0));
    send_addr(32'hFFFF_FFFF);
    send_addr(make_addr(22'd0, 6'd0, 4'hF));
    send_addr(make_addr(22'h3F_FFFF, 6'd0, 4'h0));
    send_addr(make_addr(22'd1, 6'd0, 4'h0));
    send_addr(make_addr(22'd2, 6'd0, 4'h0));
    send_addr(make_addr(22'h3F_FFFF, 6'd0, 4'h8));
    send_addr(make_addr(22'd0, 6'd0, 4'h0));
    send_addr(make_addr(22'd3, 6'd0, 4'h0));
    send_addr(make_addr(22'd1, 6'd0, 4'h0));
    send_addr(make_addr(22'd2, 6'd0, 4'h0));
    // same block back to back exercises the write-back forwarding
    send_addr(make_addr(22'd2, 6'd0, 4'h0));
    send_addr(make_addr(22'd5, 6'd63, 4'h3));
    send_addr(make_addr(22'h3F_FFFF, 6'd63, 4'hF));
    send_addr(make_addr(22'd6, 6'd1, 4'h0));
    send_addr(make_addr(22'd7, 6'd1, 4'h0));
    send_addr(make_addr(22'd8, 6'd1, 4'h0));
    send_addr(make_addr(22'd9, 6'd1, 4'h0));
    send_addr(make_addr(22'd10, 6'd1, 4'h0));
    send_addr(make_addr(22'd6, 6'd1, 4'h0));
    send_addr(32'h8000_0000);
    send_addr(32'h0000_0010);
    drain_lookups();

    send_random_phase(610);
    drain_lookups();

    snd_idle = 68;
    rcv_idle = 12;
    send_random_phase(610);

    snd_idle = 0;
    rcv_idle = 0;
    send_random_phase(610);

    drain_lookups();
    repeat (8) @(negedge clk_i);
    if (err_count == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/salru_pkg.sv
hdl/salru_tag_ram.sv
hdl/salru_lookup.sv
hdl/set_assoc_cache_lru_tags_top.sv
sim/salru_checker.sv
sim/tb_top.sv
